/* hw/rtl/lcdsmt_pkg.sv */
package lcdsmt_pkg;

	localparam logic [8:0] LINE_CYCLES   = 9'd456;
	localparam logic [9:0] SEARCH_FROM   = 10'd376;
	localparam logic [9:0] TRANSFER_FROM = 10'd204;
	localparam logic [7:0] VBLANK_LINE   = 8'd144;
	localparam logic [7:0] LAST_LINE     = 8'd153;

	typedef enum logic [1:0] {
		MODE_HBLANK   = 2'd0,
		MODE_VBLANK   = 2'd1,
		MODE_SEARCH   = 2'd2,
		MODE_TRANSFER = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_DISPLAY_ENABLE = 3'd0,
		REG_COMPARE_LINE   = 3'd1,
		REG_COINCIDENCE_IE = 3'd2,
		REG_SEARCH_IE      = 3'd3,
		REG_HBLANK_IE      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] elapsed_cycles;
		logic       draw_enable;
	} item_t;

	typedef struct packed {
		logic [7:0] current_line;
		logic [1:0] display_mode;
		logic       line_match;
		logic       status_irq;
		logic       vblank_irq;
		logic       draw_line;
	} result_t;

	typedef struct packed {
		logic       display_enable;
		logic [7:0] compare_line;
		logic       coincidence_irq_enable;
		logic       search_mode_irq_enable;
		logic       hblank_irq_enable;
	} cfg_t;

	typedef struct packed {
		logic [8:0] cnt;
		logic [7:0] line;
		mode_t      mode;
	} state_t;

endpackage

/* hw/rtl/lcdsmt_regs.sv */
module lcdsmt_regs
	import lcdsmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[4:2]);
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_enable         <= 1'b1;
			cfg_q.compare_line           <= 8'd0;
			cfg_q.coincidence_irq_enable <= 1'b0;
			cfg_q.search_mode_irq_enable <= 1'b0;
			cfg_q.hblank_irq_enable      <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_DISPLAY_ENABLE: cfg_q.display_enable         <= pwdata[0];
				REG_COMPARE_LINE:   cfg_q.compare_line           <= pwdata[7:0];
				REG_COINCIDENCE_IE: cfg_q.coincidence_irq_enable <= pwdata[0];
				REG_SEARCH_IE:      cfg_q.search_mode_irq_enable <= pwdata[0];
				REG_HBLANK_IE:      cfg_q.hblank_irq_enable      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (idx)
			REG_DISPLAY_ENABLE: prdata = {31'd0, cfg_q.display_enable};
			REG_COMPARE_LINE:   prdata = {24'd0, cfg_q.compare_line};
			REG_COINCIDENCE_IE: prdata = {31'd0, cfg_q.coincidence_irq_enable};
			REG_SEARCH_IE:      prdata = {31'd0, cfg_q.search_mode_irq_enable};
			REG_HBLANK_IE:      prdata = {31'd0, cfg_q.hblank_irq_enable};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

/* hw/rtl/lcdsmt_step.sv */
module lcdsmt_step
	import lcdsmt_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	logic signed [9:0] diff;
	logic [7:0]        line_inc;
	mode_t             mode;
	logic              want;
	logic              wrap;
	logic              vb;
	logic              draw;
	logic [7:0]        line_n;
	logic              match;

	always_comb begin
		diff     = $signed({1'b0, cur.cnt}) - $signed({4'd0, item.elapsed_cycles});
		line_inc = cur.line + 8'd1;
		want     = 1'b0;

		if (cur.line >= VBLANK_LINE) begin
			mode = MODE_VBLANK;
		end else if (diff >= $signed(SEARCH_FROM)) begin
			mode = MODE_SEARCH;
			want = cfg.search_mode_irq_enable;
		end else if (diff >= $signed(TRANSFER_FROM)) begin
			mode = MODE_TRANSFER;
		end else begin
			mode = MODE_HBLANK;
			want = cfg.hblank_irq_enable;
		end

		wrap   = diff[9] || (diff == 10'sd0);
		vb     = wrap && (line_inc == VBLANK_LINE);
		draw   = wrap && !vb && item.draw_enable && (line_inc < VBLANK_LINE);
		line_n = wrap ? ((cur.line == LAST_LINE) ? 8'd0 : line_inc) : cur.line;
		match  = (line_n == cfg.compare_line);

		if (!cfg.display_enable) begin
			nxt.cnt  = LINE_CYCLES;
			nxt.line = 8'd0;
			nxt.mode = MODE_HBLANK;
			res      = '0;
		end else begin
			nxt.cnt  = wrap ? LINE_CYCLES : diff[8:0];
			nxt.line = line_n;
			nxt.mode = vb ? MODE_VBLANK : mode;
			res.current_line = line_n;
			res.display_mode = nxt.mode;
			res.line_match   = match;
			res.status_irq   = (want && (cur.mode != mode))
				|| (match && cfg.coincidence_irq_enable);
			res.vblank_irq   = vb;
			res.draw_line    = draw;
		end
	end

endmodule

/* hw/rtl/lcd_scanline_mode_timing_unit.sv */
// Scanline mode timing for an LCD controller. Each request carries the cycles elapsed
// since the previous one and a draw permission flag; the block steps the per-line
// down-counter (reloaded from LINE_CYCLES, 154 lines), the line number and the display mode,
// and returns one result per request with line, mode, coincidence flag and the status,
// vblank and draw-line pulses. Throughput is one request per clock while the output is not
// stalled; a request is held in the input register, then goes through the update logic into
// the result register and the counter/line/mode state. Registers sit on a 32-bit APB port at
// byte offsets 0x00 (enable), 0x04 (compare line), 0x08 (coincidence irq enable), 0x0C (mode 2
// irq enable), 0x10 (mode 0 irq enable); write them only while no request is in flight.
module lcd_scanline_mode_timing_unit
	import lcdsmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg;
	logic    valid_s1;
	item_t   item_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	logic    valid_s2;
	result_t result_s2;
	logic    adv;
	logic    take;

	assign pready     = 1'b1;
	assign adv        = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign take       = item_valid && !item_stall;

	lcdsmt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lcdsmt_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			state_q.cnt   <= LINE_CYCLES;
			state_q.line  <= 8'd0;
			state_q.mode  <= MODE_HBLANK;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			result_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line <= LAST_LINE)
		else $error("line index out of range");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.cnt != 9'd0) && (state_q.cnt <= LINE_CYCLES))
		else $error("line cycle counter out of range");

	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.vblank_irq) |->
		(result.current_line == VBLANK_LINE && result.display_mode == MODE_VBLANK
		&& !result.draw_line))
		else $error("vblank pulse without vblank entry");

	a_stall_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost a request under stall");

endmodule

/* verif/tb_top.sv */
module tb_top;
	import lcdsmt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_DIRECTED = 25;

	typedef struct packed {
		bit        is_cfg;
		reg_idx_t  ridx;
		logic [7:0] value;
		item_t     req;
		bit        typed;
		result_t   res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lcd_scanline_mode_timing_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// shadow of the block: config and scan state
	cfg_t       shadow_cfg;
	int         cycles_left;
	logic [7:0] scan_line;
	mode_t      scan_mode;
	logic       coinc;

	result_t    pending_status[$];
	dir_row_t   directed_rows [NUM_DIRECTED];
	int         errors = 0;
	int         results_seen = 0;
	int         cycle_count = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         hold_left = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic result_t advance_scanline(item_t req);
		result_t r;
		mode_t   nxt;
		logic    want;
		r = '0;
		if (!shadow_cfg.display_enable) begin
			cycles_left = int'(LINE_CYCLES);
			scan_line = 8'd0;
			scan_mode = MODE_HBLANK;
			coinc = 1'b0;
		end else begin
			want = 1'b0;
			cycles_left = cycles_left - int'(req.elapsed_cycles);
			if (scan_line >= VBLANK_LINE) begin
				nxt = MODE_VBLANK;
			end else if (cycles_left >= int'(SEARCH_FROM)) begin
				nxt = MODE_SEARCH;
				want = shadow_cfg.search_mode_irq_enable;
			end else if (cycles_left >= int'(TRANSFER_FROM)) begin
				nxt = MODE_TRANSFER;
			end else begin
				nxt = MODE_HBLANK;
				want = shadow_cfg.hblank_irq_enable;
			end
			if (want && scan_mode != nxt)
				r.status_irq = 1'b1;
			if (cycles_left <= 0) begin
				scan_line = scan_line + 8'd1;
				cycles_left = int'(LINE_CYCLES);
				if (scan_line == VBLANK_LINE) begin
					r.vblank_irq = 1'b1;
					nxt = MODE_VBLANK;
				end else if (req.draw_enable && scan_line < VBLANK_LINE) begin
					r.draw_line = 1'b1;
				end
				if (scan_line > LAST_LINE)
					scan_line = 8'd0;
			end
			scan_mode = nxt;
			coinc = (scan_line == shadow_cfg.compare_line);
			if (coinc && shadow_cfg.coincidence_irq_enable)
				r.status_irq = 1'b1;
		end
		r.current_line = scan_line;
		r.display_mode = scan_mode;
		r.line_match = coinc;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
		errors++;
	endtask

	// called at a falling edge; returns at a falling edge with the request accepted
	task automatic send_request(item_t req, bit typed, result_t typed_res);
		result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = advance_scanline(req);
		pending_status.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	// called at a falling edge; waits for the block to drain first
	task automatic write_register(reg_idx_t idx, logic [7:0] value);
		item_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom()), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_DISPLAY_ENABLE: shadow_cfg.display_enable = value[0];
			REG_COMPARE_LINE:   shadow_cfg.compare_line = value;
			REG_COINCIDENCE_IE: shadow_cfg.coincidence_irq_enable = value[0];
			REG_SEARCH_IE:      shadow_cfg.search_mode_irq_enable = value[0];
			REG_HBLANK_IE:      shadow_cfg.hblank_irq_enable = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected result", 32'(result), 32'd0);
			end else begin
				want = pending_status.pop_front();
				if (result.current_line !== want.current_line)
					report_mismatch("current_line", 32'(result.current_line),
						32'(want.current_line));
				if (result.display_mode !== want.display_mode)
					report_mismatch("display_mode", 32'(result.display_mode),
						32'(want.display_mode));
				if (result.line_match !== want.line_match)
					report_mismatch("line_match", 32'(result.line_match), 32'(want.line_match));
				if (result.status_irq !== want.status_irq)
					report_mismatch("status_irq", 32'(result.status_irq), 32'(want.status_irq));
				if (result.vblank_irq !== want.vblank_irq)
					report_mismatch("vblank_irq", 32'(result.vblank_irq), 32'(want.vblank_irq));
				if (result.draw_line !== want.draw_line)
					report_mismatch("draw_line", 32'(result.draw_line), 32'(want.draw_line));
			end
			results_seen++;
		end
	end

	initial begin : stimulus
		item_t  req;
		int     n_req;
		int     cmp;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		shadow_cfg = '{1'b1, 8'd0, 1'b0, 1'b0, 1'b0};
		cycles_left = int'(LINE_CYCLES);
		scan_line = 8'd0;
		scan_mode = MODE_HBLANK;
		coinc = 1'b1;

		directed_rows = '{
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd0, 1'b0}, 1'b1,
				'{8'd0, MODE_SEARCH, 1'b1, 1'b0, 1'b0, 1'b0}},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b1}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b1}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b1}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b1}, 1'b0, '0},
			'{1'b1, REG_SEARCH_IE,      8'd1, '{6'd0, 1'b0}, 1'b0, '0},
			'{1'b1, REG_HBLANK_IE,      8'd1, '{6'd0, 1'b0}, 1'b0, '0},
			'{1'b1, REG_COMPARE_LINE,   8'd1, '{6'd0, 1'b0}, 1'b0, '0},
			'{1'b1, REG_COINCIDENCE_IE, 8'd1, '{6'd0, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd1, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd42, 1'b1}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd21, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b0}, 1'b0, '0},
			'{1'b1, REG_COMPARE_LINE,   8'd255, '{6'd0, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b1}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b0}, 1'b0, '0},
			'{1'b1, REG_DISPLAY_ENABLE, 8'd0, '{6'd0, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd63, 1'b1}, 1'b1,
				'{8'd0, MODE_HBLANK, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{1'b1, REG_DISPLAY_ENABLE, 8'd1, '{6'd0, 1'b0}, 1'b0, '0},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd0, 1'b0}, 1'b1,
				'{8'd0, MODE_SEARCH, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{1'b0, REG_DISPLAY_ENABLE, 8'd0, '{6'd62, 1'b1}, 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_register(directed_rows[i].ridx, directed_rows[i].value);
			else
				send_request(directed_rows[i].req, directed_rows[i].typed,
					directed_rows[i].res);
		end

		// mostly full-size steps so the scan advances through many lines
		for (int p = 0; p < 9; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			if (p == 0)
				cmp = 0;
			else if (p == 2)
				cmp = 255;
			else
				cmp = (int'(scan_line) + $urandom_range(20, 1) > int'(LAST_LINE)) ?
					int'(LAST_LINE) : int'(scan_line) + $urandom_range(20, 1);
			write_register(REG_DISPLAY_ENABLE, (p == 1) ? 8'd0 : 8'd1);
			write_register(REG_COMPARE_LINE, 8'(cmp));
			write_register(REG_COINCIDENCE_IE, 8'($urandom_range(1)));
			write_register(REG_SEARCH_IE, 8'($urandom_range(1)));
			write_register(REG_HBLANK_IE, 8'($urandom_range(1)));
			if (p == 5)
				hold_left = 400;
			n_req = (p == 1) ? 20 : ((p == 0) ? 150 : 160);
			for (int k = 0; k < n_req; k++) begin
				req.elapsed_cycles = ($urandom_range(99) < 80) ? 6'd63 :
					6'($urandom_range(63));
				req.draw_enable = 1'($urandom_range(1));
				send_request(req, 1'b0, '0);
			end
		end

		item_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
